FILE: src/interval_load_peak_finder_macros.svh
// Assertion macros shared by the interval load peak finder RTL.
`ifndef INTERVAL_LOAD_PEAK_FINDER_MACROS_SVH
`define INTERVAL_LOAD_PEAK_FINDER_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define ILPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Check a property on every clock edge, reset included.
`define ILPF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define ILPF_ASSERT(lbl, prop, msg)
`define ILPF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: src/ilpf_pkg.sv
// Shared types, codes and helpers of the interval load peak finder.
`default_nettype none
package ilpf_pkg;

  localparam int SLOTS_DEF    = 1024;
  localparam int MAX_RUNS_DEF = 63;

  // Operation codes of an input word
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Result kinds
  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // What the sweep does with each slot
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_CLEAR,
    MODE_ADD,
    MODE_PEAK,
    MODE_RUNS
  } mode_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic  add_load;    // capture add word, start sweep over its range
    logic  scan_init;   // start peak sweep below highest end
    logic  runs_init;   // start run sweep below highest end
    logic  step;        // advance sweep by one slot
    mode_t mode;
    logic  emit_peak;   // send peak value word
    logic  emit_run;    // send next run word
    logic  report_done; // drop highest end and run count
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic pipe_busy;
    logic no_runs;
    logic last_run;
  } sts_t;

  // Add a 16-bit load to a slot total, saturating at signed 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [15:0] b);
    logic [32:0] s;
    s = {a[31], a} + {{17{b[15]}}, b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/ilpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ilpf_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/ilpf_ctrl.sv
// Controller state machine of the interval load peak finder.
`default_nettype none
module ilpf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          op,
  input  wire ilpf_pkg::sts_t sts,
  output ilpf_pkg::cmd_t     cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_PEAK,
    ST_RUNS,
    ST_EMIT_PEAK,
    ST_EMIT_RUNS
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   drained;

  assign drained = sts.sweep_done && !sts.pipe_busy;
  assign busy    = (state_r != ST_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    cmd.mode  = ilpf_pkg::MODE_IDLE;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.mode = ilpf_pkg::MODE_CLEAR;
        cmd.step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (op == ilpf_pkg::OP_ADD) begin
            cmd.add_load = 1'b1;
            state_nxt    = ST_ADD;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_PEAK;
          end
        end
      end
      ST_ADD: begin
        cmd.mode = ilpf_pkg::MODE_ADD;
        cmd.step = 1'b1;
        if (drained) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PEAK: begin
        cmd.mode = ilpf_pkg::MODE_PEAK;
        cmd.step = 1'b1;
        if (drained) begin
          cmd.runs_init = 1'b1;
          state_nxt     = ST_RUNS;
        end
      end
      ST_RUNS: begin
        cmd.mode = ilpf_pkg::MODE_RUNS;
        cmd.step = 1'b1;
        if (drained) begin
          state_nxt = ST_EMIT_PEAK;
        end
      end
      ST_EMIT_PEAK: begin
        cmd.emit_peak = 1'b1;
        if (sts.no_runs) begin
          cmd.report_done = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT_RUNS;
        end
      end
      ST_EMIT_RUNS: begin
        cmd.emit_run = 1'b1;
        if (sts.last_run) begin
          cmd.report_done = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/ilpf_dp.sv
// Datapath of the interval load peak finder: slot store, sweep, peak and runs.
`default_nettype none
`include "interval_load_peak_finder_macros.svh"
module ilpf_dp #(
  parameter int SLOTS    = ilpf_pkg::SLOTS_DEF,
  parameter int MAX_RUNS = ilpf_pkg::MAX_RUNS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ilpf_pkg::cmd_t     cmd,
  output ilpf_pkg::sts_t          sts,
  input  wire logic signed [15:0] in_load_value,
  input  wire logic [9:0]         in_range_start,
  input  wire logic [10:0]        in_range_end,
  output logic                    out_valid,
  output logic                    out_result_kind,
  output logic signed [31:0]      out_peak_value,
  output logic [9:0]              out_run_first,
  output logic [10:0]             out_run_limit,
  output logic                    out_truncated,
  output logic                    out_last
);

  localparam int AW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int RAW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int RCW = $clog2(MAX_RUNS + 2);
  localparam int RW  = AW + CW;

  // Sweep and item registers
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       lim_r;
  logic [CW-1:0]       hend_r;
  logic signed [15:0]  load_r;
  logic                pv_r;
  logic [AW-1:0]       pa_r;
  logic signed [31:0]  peak_r;
  logic                inrun_r;
  logic [AW-1:0]       lo_r;
  logic [RCW-1:0]      runs_r;
  logic [RAW-1:0]      er_r;

  // Output registers
  logic                out_valid_r;
  logic                out_kind_r;
  logic signed [31:0]  out_peak_r;
  logic [9:0]          out_first_r;
  logic [10:0]         out_limit_r;
  logic                out_trunc_r;
  logic                out_last_r;

  // Slot store ports
  logic                s_we;
  logic [AW-1:0]       s_waddr;
  logic signed [31:0]  s_wdata;
  logic signed [31:0]  s_rdata;

  // Run store ports
  logic                r_we;
  logic [RAW-1:0]      r_waddr;
  logic [RW-1:0]       r_wdata;
  logic [RAW-1:0]      r_raddr;
  logic [RW-1:0]       r_rdata;

  logic [31:0]         end32;
  logic [31:0]         st32;
  logic [CW-1:0]       end_c;
  logic                sweep_done;
  logic                issue;
  logic                pv_nxt;
  logic                in_runs;
  logic                at_peak;
  logic                last_slot;
  logic                close_miss;
  logic                close_end;
  logic                run_close;
  logic [AW-1:0]       run_lo;
  logic [CW-1:0]       run_lim;
  logic [RCW-1:0]      kept;
  logic                trunc;
  logic                no_runs;
  logic                last_run;

  // Clamp the add range to the store
  assign end32 = (32'(in_range_end) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(in_range_end);
  assign st32  = 32'(in_range_start);
  assign end_c = CW'(end32);

  // Sweep control
  assign sweep_done = (idx_r >= lim_r);
  assign issue      = cmd.step && !sweep_done;
  assign pv_nxt     = issue && (cmd.mode != ilpf_pkg::MODE_CLEAR);

  // Slot store write: clear directly, or write back behind the read
  always_comb begin
    s_we    = 1'b0;
    s_waddr = pa_r;
    s_wdata = '0;
    if (cmd.mode == ilpf_pkg::MODE_CLEAR) begin
      s_we    = issue;
      s_waddr = idx_r[AW-1:0];
    end else if (cmd.mode == ilpf_pkg::MODE_ADD) begin
      s_we    = pv_r;
      s_wdata = ilpf_pkg::sat_add(s_rdata, load_r);
    end else if (cmd.mode == ilpf_pkg::MODE_RUNS) begin
      s_we = pv_r;
    end
  end

  // Run detection on the slot read back
  assign in_runs    = pv_r && (cmd.mode == ilpf_pkg::MODE_RUNS);
  assign at_peak    = (s_rdata == peak_r);
  assign last_slot  = ((CW'(pa_r) + CW'(1)) == lim_r);
  assign close_miss = in_runs && inrun_r && !at_peak;
  assign close_end  = in_runs && at_peak && last_slot;
  assign run_close  = close_miss || close_end;
  assign run_lo     = inrun_r ? lo_r : pa_r;
  assign run_lim    = close_end ? (CW'(pa_r) + CW'(1)) : CW'(pa_r);

  // Keep only the first runs
  assign r_we    = run_close && (runs_r < RCW'(MAX_RUNS));
  assign r_waddr = runs_r[RAW-1:0];
  assign r_wdata = {run_lo, run_lim};

  // Report bookkeeping
  assign trunc    = (runs_r > RCW'(MAX_RUNS));
  assign kept     = trunc ? RCW'(MAX_RUNS) : runs_r;
  assign no_runs  = (runs_r == '0);
  assign last_run = ((RCW'(er_r) + RCW'(1)) == kept);

  // Read run store one word ahead of emission
  always_comb begin
    if (cmd.emit_peak) begin
      r_raddr = '0;
    end else if (last_run) begin
      r_raddr = er_r;
    end else begin
      r_raddr = er_r + RAW'(1);
    end
  end

  assign sts.sweep_done = sweep_done;
  assign sts.pipe_busy  = pv_r;
  assign sts.no_runs    = no_runs;
  assign sts.last_run   = last_run;

  ilpf_ram #(
    .W     (32),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (s_rdata)
  );

  ilpf_ram #(
    .W     (RW),
    .DEPTH (MAX_RUNS)
  ) u_run_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // Advance sweep, track peak and runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      lim_r   <= CW'(SLOTS);
      hend_r  <= '0;
      pv_r    <= 1'b0;
      inrun_r <= 1'b0;
      runs_r  <= '0;
      er_r    <= '0;
    end else begin
      pv_r <= pv_nxt;
      if (issue) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.add_load) begin
        idx_r <= (st32 >= end32) ? end_c : CW'(st32);
        lim_r <= end_c;
        if (end_c > hend_r) begin
          hend_r <= end_c;
        end
      end
      if (cmd.scan_init || cmd.runs_init) begin
        idx_r <= '0;
        lim_r <= hend_r;
      end
      if (cmd.runs_init) begin
        inrun_r <= 1'b0;
        runs_r  <= '0;
      end
      if (in_runs) begin
        inrun_r <= at_peak && !last_slot;
      end
      if (run_close && !trunc) begin
        runs_r <= runs_r + RCW'(1);
      end
      if (cmd.emit_peak) begin
        er_r <= '0;
      end else if (cmd.emit_run) begin
        er_r <= er_r + RAW'(1);
      end
      if (cmd.report_done) begin
        hend_r <= '0;
        runs_r <= '0;
      end
    end
  end

  // Item payload and run start
  always_ff @(posedge clk) begin
    if (cmd.add_load) begin
      load_r <= in_load_value;
    end
    pa_r <= idx_r[AW-1:0];
    if (cmd.scan_init) begin
      peak_r <= '0;
    end else if (pv_r && (cmd.mode == ilpf_pkg::MODE_PEAK) && (s_rdata > peak_r)) begin
      peak_r <= s_rdata;
    end
    if (in_runs && at_peak && !inrun_r) begin
      lo_r <= pa_r;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_peak || cmd.emit_run;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.emit_peak) begin
      out_kind_r  <= ilpf_pkg::KIND_PEAK;
      out_peak_r  <= peak_r;
      out_first_r <= '0;
      out_limit_r <= '0;
      out_trunc_r <= trunc;
      out_last_r  <= no_runs;
    end else if (cmd.emit_run) begin
      out_kind_r  <= ilpf_pkg::KIND_RUN;
      out_peak_r  <= peak_r;
      out_first_r <= 10'(r_rdata[RW-1 -: AW]);
      out_limit_r <= 11'(r_rdata[CW-1:0]);
      out_trunc_r <= trunc;
      out_last_r  <= last_run;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_peak_value  = out_peak_r;
  assign out_run_first   = out_first_r;
  assign out_run_limit   = out_limit_r;
  assign out_truncated   = out_trunc_r;
  assign out_last        = out_last_r;

  `ILPF_ASSERT(a_pipe_addr, pv_r |-> (32'(pa_r) < 32'(SLOTS)), "slot address beyond store")
  `ILPF_ASSERT(a_emit_has_run, cmd.emit_run |-> !no_runs, "run word sent with no runs")

endmodule
`default_nettype wire

FILE: src/interval_load_peak_finder.sv
// Top level of the interval load peak finder.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | in_operation, in_load_value, in_range_* | taken when start & !busy
//  result  | out_result_kind .. out_last             | out_valid strobe, one cycle
//
// Add word: one slot per cycle is read from the slot RAM and written back.
// Finish word: peak sweep, run sweep that zeroes each slot, then one result
// word per cycle from the run RAM. After reset the block zeroes all SLOTS
// slots, with busy high. Result words are registered; the receiver cannot
// stall, so they leave back to back.
`default_nettype none
`include "interval_load_peak_finder_macros.svh"
module interval_load_peak_finder #(
  parameter int SLOTS    = ilpf_pkg::SLOTS_DEF,
  parameter int MAX_RUNS = ilpf_pkg::MAX_RUNS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_operation,
  input  wire logic signed [15:0] in_load_value,
  input  wire logic [9:0]         in_range_start,
  input  wire logic [10:0]        in_range_end,
  output logic                    out_valid,
  output logic                    out_result_kind,
  output logic signed [31:0]      out_peak_value,
  output logic [9:0]              out_run_first,
  output logic [10:0]             out_run_limit,
  output logic                    out_truncated,
  output logic                    out_last
);

  ilpf_pkg::cmd_t cmd;
  ilpf_pkg::sts_t sts;

  // Sequence the sweeps and the report
  ilpf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_operation),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Store, peak search and run capture
  ilpf_dp #(
    .SLOTS    (SLOTS),
    .MAX_RUNS (MAX_RUNS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_load_value   (in_load_value),
    .in_range_start  (in_range_start),
    .in_range_end    (in_range_end),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_peak_value  (out_peak_value),
    .out_run_first   (out_run_first),
    .out_run_limit   (out_run_limit),
    .out_truncated   (out_truncated),
    .out_last        (out_last)
  );

  `ILPF_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted word did not raise busy")
  `ILPF_ASSERT(a_report_contig, out_valid && !out_last |=> out_valid, "report word gap")
  `ILPF_ASSERT(a_report_busy, out_valid && !out_last |-> busy, "idle in middle of report")
  `ILPF_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "result strobe after reset")

endmodule
`default_nettype wire

FILE: dv/interval_load_peak_finder_tb.sv
// Testbench for the interval load peak finder: driver, monitor and load/peak predictor.
`timescale 1ns / 1ps
module interval_load_peak_finder_tb;

  localparam int SLOTS       = ilpf_pkg::SLOTS_DEF;
  localparam int MAX_RUNS    = ilpf_pkg::MAX_RUNS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2 * SLOTS + 150;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  // One word on the input channel; dense words skip the sender's gaps
  typedef struct {
    logic               op;
    logic signed [15:0] load;
    logic [9:0]         first_slot;
    logic [10:0]        end_slot;
    bit                 dense;
  } sweep_word_t;

  // One word of a peak report
  typedef struct {
    logic               kind;
    logic signed [31:0] peak;
    logic [9:0]         first;
    logic [10:0]        limit;
    logic               trunc;
    logic               last;
  } peak_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_operation = 1'b0;
  logic signed [15:0] in_load_value = '0;
  logic [9:0]         in_range_start = '0;
  logic [10:0]        in_range_end = '0;
  logic               out_valid;
  logic               out_result_kind;
  logic signed [31:0] out_peak_value;
  logic [9:0]         out_run_first;
  logic [10:0]        out_run_limit;
  logic               out_truncated;
  logic               out_last;

  sweep_word_t  sweep_words [$];
  peak_report_t peak_reports_due [$];
  logic signed [31:0] slot_sum [SLOTS];
  int unsigned  sweep_end;
  int           mismatches = 0;
  int           words_queued = 0;

  interval_load_peak_finder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_load_value   (in_load_value),
    .in_range_start  (in_range_start),
    .in_range_end    (in_range_end),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_peak_value  (out_peak_value),
    .out_run_first   (out_run_first),
    .out_run_limit   (out_run_limit),
    .out_truncated   (out_truncated),
    .out_last        (out_last)
  );

  always #1 clk = ~clk;

  // Apply an accepted word to the slot totals; on finish, queue the report it causes
  task automatic apply_word(input sweep_word_t w);
    int unsigned stop, s, runs, kept;
    longint total;
    logic signed [31:0] peak;
    bit in_run, trunc;
    int unsigned run_first [$];
    int unsigned run_limit [$];
    peak_report_t r;
    if (w.op == ilpf_pkg::OP_ADD) begin
      stop = (w.end_slot > SLOTS) ? SLOTS : w.end_slot;
      for (s = w.first_slot; s < stop; s++) begin
        total = longint'(slot_sum[s]) + longint'(w.load);
        if (total > SUM_MAX) total = SUM_MAX;
        else if (total < SUM_MIN) total = SUM_MIN;
        slot_sum[s] = total[31:0];
      end
      if (stop > sweep_end) sweep_end = stop;
    end else begin
      peak = '0;
      for (s = 0; s < sweep_end; s++) begin
        if (slot_sum[s] > peak) peak = slot_sum[s];
      end
      // collect maximal runs at the peak, in slot order
      in_run = 1'b0;
      for (s = 0; s < sweep_end; s++) begin
        if (slot_sum[s] == peak && !in_run) begin
          in_run = 1'b1;
          run_first.push_back(s);
        end
        if (in_run && (s + 1 == sweep_end || slot_sum[s + 1] != peak)) begin
          in_run = 1'b0;
          run_limit.push_back(s + 1);
        end
      end
      runs  = run_limit.size();
      trunc = runs > MAX_RUNS;
      kept  = trunc ? MAX_RUNS : runs;
      r = '{ilpf_pkg::KIND_PEAK, peak, 10'd0, 11'd0, trunc, kept == 0};
      peak_reports_due.push_back(r);
      for (s = 0; s < kept; s++) begin
        r = '{ilpf_pkg::KIND_RUN, peak, 10'(run_first[s]), 11'(run_limit[s]), trunc,
              s + 1 == kept};
        peak_reports_due.push_back(r);
      end
      foreach (slot_sum[i]) slot_sum[i] = '0;
      sweep_end = 0;
    end
  endtask

  function automatic logic signed [15:0] pick_load();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 6) - 3);
    endcase
  endfunction

  task automatic queue_add(input logic signed [15:0] load, input int unsigned first,
                           input int unsigned stop, input bit dense = 1'b0);
    sweep_words.push_back('{ilpf_pkg::OP_ADD, load, 10'(first), 11'(stop), dense});
    words_queued++;
  endtask

  // Finish words carry random junk in the fields the block ignores
  task automatic queue_finish();
    sweep_words.push_back('{ilpf_pkg::OP_FINISH, 16'($urandom), 10'($urandom),
                            11'($urandom), 1'b0});
    words_queued++;
  endtask

  // Negative loads on every other slot, then an empty range that stretches the
  // highest end: leaves count + 1 runs of zero-valued slots
  task automatic queue_runs(input int unsigned count);
    int unsigned base, k;
    base = $urandom_range(0, 880);
    for (k = 0; k < count; k++) begin
      queue_add(16'($urandom_range(32768, 65535)), base + 2 * k + 1, base + 2 * k + 2);
    end
    queue_add(pick_load(), $urandom_range(base + 2 * count + 1, 1023), base + 2 * count + 1);
    queue_finish();
  endtask

  // Random groups: adds in a shared window followed by a finish, with some noise
  task automatic queue_random_groups(input int upto);
    int unsigned base, f, n;
    while (words_queued < upto) begin
      if ($urandom_range(0, 9) == 0) begin
        sweep_words.push_back('{1'($urandom), 16'($urandom), 10'($urandom),
                                11'($urandom), 1'b0});
        words_queued++;
      end else begin
        base = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 960) : $urandom_range(0, 40);
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0) begin
            queue_add(pick_load(), $urandom_range(0, 1023), $urandom_range(0, 2047));
          end else begin
            f = base + $urandom_range(0, 40);
            queue_add(pick_load(), f, f + $urandom_range(0, 20));
          end
        end
        queue_finish();
      end
    end
  endtask

  // Driver: hold each word until taken, sending in bursts with gaps between them
  sweep_word_t cur_word = '{ilpf_pkg::OP_ADD, 16'sd0, 10'd0, 11'd0, 1'b0};
  bit word_up = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        apply_word(cur_word);
        word_up = 1'b0;
      end
      if (!word_up && sweep_words.size() != 0) begin
        if (gap_left > 0 && !sweep_words[0].dense) begin
          gap_left--;
        end else begin
          cur_word = sweep_words.pop_front();
          word_up  = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
    start          <= word_up;
    in_operation   <= cur_word.op;
    in_load_value  <= cur_word.load;
    in_range_start <= cur_word.first_slot;
    in_range_end   <= cur_word.end_slot;
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each result word with the oldest expected report word
  always @(posedge clk) begin
    peak_report_t exp_word;
    if (rst_n && out_valid) begin
      if (peak_reports_due.size() == 0) begin
        $display("%0t: unexpected result word: kind %0h peak %0h first %0h limit %0h",
                 $time, out_result_kind, out_peak_value, out_run_first, out_run_limit);
        mismatches++;
      end else begin
        exp_word = peak_reports_due.pop_front();
        check_field("result_kind", exp_word.kind, out_result_kind);
        check_field("peak_value", exp_word.peak, out_peak_value);
        check_field("run_first", exp_word.first, out_run_first);
        check_field("run_limit", exp_word.limit, out_run_limit);
        check_field("truncated", exp_word.trunc, out_truncated);
        check_field("last", exp_word.last, out_last);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (slot_sum[i]) slot_sum[i] = '0;
    sweep_end = 0;

    // Finish with nothing added
    queue_finish();
    // Full range, clamped end, empty and reversed ranges, field extremes
    queue_add(16'sh7fff, 0, 1024);
    queue_add(16'sh8000, 1023, 2047);
    queue_add(16'sd5, 10, 10);
    queue_add(16'sd7, 700, 3);
    queue_add(16'sd1, 512, 514);
    queue_finish();
    // Peak of zero with several zero runs
    queue_add(-16'sd3, 4, 9);
    queue_add(16'sd0, 0, 20);
    queue_add(-16'sd1, 12, 13);
    queue_finish();
    // Reversed range only raises the highest end
    queue_add(16'sd9, 900, 30);
    queue_finish();
    // Equal peaks in separate runs, last run ending at the highest end
    queue_add(16'sd6, 1, 3);
    queue_add(16'sd6, 5, 6);
    queue_add(16'sd3, 8, 10);
    queue_add(16'sd3, 8, 10);
    queue_finish();
    // Peak in the top slot
    queue_add(16'sd100, 1023, 1024);
    queue_add(-16'sd1, 0, 1023);
    queue_finish();

    queue_random_groups(100);
    queue_runs(MAX_RUNS - 1);
    queue_runs(MAX_RUNS);
    queue_random_groups(230);
    queue_finish();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every word taken and every report word seen
    while (sweep_words.size() != 0 || word_up || peak_reports_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && peak_reports_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/ilpf_pkg.sv
src/ilpf_ram.sv
src/ilpf_ctrl.sv
src/ilpf_dp.sv
src/interval_load_peak_finder.sv
dv/interval_load_peak_finder_tb.sv
